// File: rtl/core/enfa_pkg.sv
`timescale 1ns / 1ps

package enfa_pkg;

  localparam int NumStates   = 16;
  localparam int SymbolWidth = 8;
  localparam int StateW      = $clog2(NumStates);
  localparam int CntW        = StateW + 1;
  localparam int AddrW       = StateW + SymbolWidth;
  localparam int SiuW        = 5;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 16;
  localparam int InDataW     = 32;
  localparam int OutDataW    = 8;

  typedef logic [NumStates-1:0] set_t;

  typedef enum logic [1:0] {
    OP_LOAD_SYM = 2'd0,
    OP_LOAD_EPS = 2'd1,
    OP_FEED     = 2'd2,
    OP_EMPTY    = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_STATE   = 2'd0,
    CFG_ACCEPT_MASK   = 2'd1,
    CFG_STATES_IN_USE = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLOSE,
    ST_READ,
    ST_EMIT
  } state_e;

endpackage

// File: rtl/core/epsilon_nfa_string_acceptor_unit.sv
`timescale 1ns / 1ps

// Epsilon-NFA string acceptor, one item at a time. A load item is taken in the idle state. A
// symbol item reads the transition rows of the active states, then repeats closure passes
// until the set stops growing; the first symbol of a string is preceded by a start-state
// closure, and the last symbol ends with a result. An empty-string item closes and emits.
// After an asynchronous active-low reset all 4096 entries of the transition memory are
// swept to zero, one entry a cycle, before the first item is accepted.
module epsilon_nfa_string_acceptor_unit
  import enfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // Input items.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // Fields from bit 0: state_index[3:0], symbol[11:4], dest_mask[27:12], zero pad.
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // Fields from bit 0: operation[1:0].
  input  logic [1:0]          s_axis_tuser_i,
  // last_symbol.
  input  logic                s_axis_tlast_i,
  // Result items.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // Fields from bit 0: accepted[0], zero pad.
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  // Transition memory: one row of destinations per (state, symbol) pair.
  localparam int Depth = NumStates << SymbolWidth;

  set_t              sym_mem [Depth];
  set_t              mem_rdata_q;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  set_t              mem_wdata;
  logic [AddrW-1:0]  mem_raddr;

  // Epsilon moves are few enough to live in flops; the closure reads every row.
  set_t              eps_q [NumStates];

  state_e            state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  set_t              set_q, set_d;
  set_t              acc_q, acc_d;
  set_t              active_q, active_d;
  logic              in_str_q, in_str_d;
  logic              phase_sym_q, phase_sym_d;  // closure follows a symbol step
  op_e               op_q, op_d;
  logic [SymbolWidth-1:0] sym_q, sym_d;
  logic              last_q, last_d;
  logic              rvld_q, rvld_d;
  logic              res_q, res_d;
  logic              out_vld_q, out_vld_d;
  logic              out_acc_q, out_acc_d;

  logic [StateW-1:0] start_q;
  set_t              amask_q;
  logic [SiuW-1:0]   siu_q;

  logic              in_fire;
  logic              slot_free;
  op_e               in_op;
  logic [StateW-1:0] in_state;
  logic [SymbolWidth-1:0] in_sym;
  set_t              in_dest;
  set_t              used;
  logic [SiuW-1:0]   n_eff;
  set_t              eps_or;
  set_t              clos_next;
  logic              clos_done;
  set_t              start_bit;
  set_t              step_set;

  assign in_op    = op_e'(s_axis_tuser_i);
  assign in_state = s_axis_tdata_i[StateW-1:0];
  assign in_sym   = s_axis_tdata_i[StateW +: SymbolWidth];
  assign in_dest  = s_axis_tdata_i[AddrW +: NumStates];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !out_vld_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutDataW-1){1'b0}}, out_acc_q};

  // Only the states in use take part; zero counts as one, large values saturate.
  always_comb begin
    n_eff = siu_q;
    if (siu_q == '0) begin
      n_eff = SiuW'(1);
    end else if (siu_q > SiuW'(NumStates)) begin
      n_eff = SiuW'(NumStates);
    end
    for (int i = 0; i < NumStates; i++) begin
      used[i] = (SiuW'(i) < n_eff);
    end
  end

  assign start_bit = set_t'(1) << start_q;

  // One closure pass: add the epsilon rows of every state in the set. States out
  // of use are dropped before their rows could contribute anything.
  always_comb begin
    eps_or = '0;
    for (int i = 0; i < NumStates; i++) begin
      if (set_q[i] && used[i]) begin
        eps_or = eps_or | eps_q[i];
      end
    end
    clos_next = (set_q | eps_or) & used;
    clos_done = (clos_next == set_q);
  end

  // Union so far including the row that arrives this cycle.
  assign step_set = acc_q | (rvld_q ? mem_rdata_q : '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            OP_LOAD_SYM, OP_LOAD_EPS: state_d = ST_IDLE;
            OP_FEED:  state_d = in_str_q ? ST_READ : ST_CLOSE;
            OP_EMPTY: state_d = ST_CLOSE;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLOSE: begin
        if (clos_done) begin
          if (!phase_sym_q) begin
            state_d = (op_q == OP_EMPTY) ? ST_EMIT : ST_READ;
          end else begin
            state_d = last_q ? ST_EMIT : ST_IDLE;
          end
        end
      end
      ST_READ: begin
        if (cnt_q == CntW'(NumStates)) begin
          state_d = ST_CLOSE;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    set_d       = set_q;
    acc_d       = acc_q;
    active_d    = active_q;
    in_str_d    = in_str_q;
    phase_sym_d = phase_sym_q;
    op_d        = op_q;
    sym_d       = sym_q;
    last_d      = last_q;
    rvld_d      = 1'b0;
    res_d       = res_q;
    out_vld_d   = out_vld_q;
    out_acc_d   = out_acc_q;
    mem_we      = 1'b0;
    mem_waddr   = {in_state, in_sym};
    mem_wdata   = in_dest;
    mem_raddr   = {cnt_q[StateW-1:0], sym_q};

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          op_d        = in_op;
          sym_d       = in_sym;
          last_d      = s_axis_tlast_i;
          phase_sym_d = 1'b0;
          cnt_d       = '0;
          acc_d       = '0;
          unique case (in_op)
            OP_LOAD_SYM: mem_we = 1'b1;
            OP_LOAD_EPS: mem_we = 1'b0;
            OP_FEED: begin
              set_d = in_str_q ? active_q : start_bit;
            end
            OP_EMPTY: begin
              // Any string in progress is dropped without a result.
              in_str_d = 1'b0;
              active_d = '0;
              set_d    = start_bit;
            end
            default: mem_we = 1'b0;
          endcase
        end
      end
      ST_CLOSE: begin
        set_d = clos_next;
        if (clos_done) begin
          if (!phase_sym_q) begin
            if (op_q == OP_EMPTY) begin
              res_d = |(set_q & amask_q);
            end else begin
              active_d = set_q;
              cnt_d    = '0;
              acc_d    = '0;
            end
          end else if (last_q) begin
            res_d    = |(set_q & amask_q);
            in_str_d = 1'b0;
            active_d = '0;
          end else begin
            active_d = set_q;
            in_str_d = 1'b1;
          end
        end
      end
      ST_READ: begin
        // Issue one row read per state; the row lands in the following cycle.
        acc_d = step_set;
        if (cnt_q == CntW'(NumStates)) begin
          set_d       = step_set;
          phase_sym_d = 1'b1;
        end else begin
          rvld_d = active_q[cnt_q[StateW-1:0]];
          cnt_d  = cnt_q + CntW'(1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          out_acc_d = res_q;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sym_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= sym_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStates; i++) begin
        eps_q[i] <= '0;
      end
    end else if (in_fire && in_op == OP_LOAD_EPS) begin
      eps_q[in_state] <= in_dest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      amask_q <= '0;
      siu_q   <= SiuW'(NumStates);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_START_STATE:   start_q <= cfg_wdata_i[StateW-1:0];
        CFG_ACCEPT_MASK:   amask_q <= cfg_wdata_i[NumStates-1:0];
        CFG_STATES_IN_USE: siu_q   <= cfg_wdata_i[SiuW-1:0];
        CFG_UNUSED:        siu_q   <= siu_q;
        default:           siu_q   <= siu_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      active_q    <= '0;
      in_str_q    <= 1'b0;
      phase_sym_q <= 1'b0;
      rvld_q      <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      active_q    <= active_d;
      in_str_q    <= in_str_d;
      phase_sym_q <= phase_sym_d;
      rvld_q      <= rvld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q     <= set_d;
    acc_q     <= acc_d;
    op_q      <= op_d;
    sym_q     <= sym_d;
    last_q    <= last_d;
    res_q     <= res_d;
    out_acc_q <= out_acc_d;
  end

endmodule

// File: bench/epsilon_nfa_string_acceptor_unit_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the epsilon-NFA string acceptor. A behavioral copy
// of the automaton (transition tables, active set, string flag and registers)
// runs beside the block and predicts the accept verdict of every finished
// string. Verdicts are queued in order and matched against each result item.
module epsilon_nfa_string_acceptor_unit_tb;
  import enfa_pkg::*;

  localparam int          CYCLE_LIMIT  = 300000;
  // Outlasts the longest symbol item, so this covers items without results.
  localparam int          QUIET_CYCLES = 80;
  localparam logic [7:0]  AMPERSAND    = 8'h26;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr_i      = '0;
  logic [CfgDataW-1:0] cfg_wdata_i     = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // Fields from bit 0: state_index[3:0], symbol[11:4], dest_mask[27:12], zero pad.
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  // Fields from bit 0: operation[1:0].
  logic [1:0]          s_axis_tuser_i  = '0;
  logic                s_axis_tlast_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // Fields from bit 0: accepted[0], zero pad.
  logic [OutDataW-1:0] m_axis_tdata_o;

  epsilon_nfa_string_acceptor_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  // Behavioral copy of the automaton. Both tables start cleared, like the
  // block after its clearing sweep.
  set_t       sym_rows [NumStates][1 << SymbolWidth];
  set_t       eps_rows [NumStates];
  set_t       live_set;
  logic       mid_string;
  logic [3:0] cfg_start;
  set_t       cfg_accept;
  logic [4:0] cfg_siu;

  logic expected_verdicts [$];
  int   err_count   = 0;
  int   cycle_count = 0;
  // When set, both sides run without idle cycles.
  logic calm        = 1'b0;

  // A states_in_use of zero behaves as one, and anything above the state
  // count behaves as the full state count.
  function automatic set_t in_use_mask();
    int n;
    n = cfg_siu;
    if (n == 0) n = 1;
    if (n > NumStates) n = NumStates;
    return set_t'((32'd1 << n) - 32'd1);
  endfunction

  // Epsilon closure restricted to the states in use. Running all passes is
  // harmless: once the set stops growing it stays fixed, so loops are fine.
  function automatic set_t eps_closure(set_t seed);
    set_t used;
    set_t cur;
    set_t nxt;
    used = in_use_mask();
    cur  = seed & used;
    for (int pass = 0; pass < NumStates; pass++) begin
      nxt = cur;
      for (int s = 0; s < NumStates; s++)
        if (cur[s]) nxt |= eps_rows[s];
      cur = nxt & used;
    end
    return cur;
  endfunction

  // A start state outside the states in use yields an empty start set.
  function automatic set_t start_closure();
    return eps_closure(set_t'(1) << cfg_start);
  endfunction

  task automatic predict_verdict(input op_e op, input logic [3:0] st,
                                 input logic [7:0] sym, input set_t dest,
                                 input logic last);
    set_t nxt;
    begin
      case (op)
        OP_LOAD_SYM: sym_rows[st][sym] = dest;
        OP_LOAD_EPS: eps_rows[st] = dest;
        OP_EMPTY: begin
          // Any open string is dropped without a verdict of its own.
          mid_string = 1'b0;
          live_set   = '0;
          expected_verdicts.push_back(|(start_closure() & cfg_accept));
        end
        default: begin
          if (!mid_string) live_set = start_closure();
          nxt = '0;
          for (int s = 0; s < NumStates; s++)
            if (live_set[s]) nxt |= sym_rows[s][sym];
          nxt = eps_closure(nxt);
          if (last) begin
            mid_string = 1'b0;
            live_set   = '0;
            expected_verdicts.push_back(|(nxt & cfg_accept));
          end else begin
            mid_string = 1'b1;
            live_set   = nxt;
          end
        end
      endcase
    end
  endtask

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Offers one item after a random gap and returns at the edge where it is
  // taken. The predictor runs at that same edge.
  task automatic offer_item(input op_e op, input logic [3:0] st, input logic [7:0] sym,
                            input set_t dest, input logic last);
    int gap;
    begin
      gap = draw_gap();
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= {4'b0, dest, sym, st};
      s_axis_tuser_i  <= op;
      s_axis_tlast_i  <= last;
      do @(posedge clk_i); while (!s_axis_tready_o);
      predict_verdict(op, st, sym, dest, last);
    end
  endtask

  // Feeds one symbol with random content in the fields that a feed ignores.
  task automatic feed_symbol(input logic [7:0] sym, input logic last);
    offer_item(OP_FEED, 4'($urandom_range(0, 15)), sym,
               set_t'($urandom_range(0, 65535)), last);
  endtask

  // An empty-string item, also with random ignored fields.
  task automatic feed_empty();
    offer_item(OP_EMPTY, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
               set_t'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  // Lets the block go quiet: every verdict back, then time for any symbol
  // item that ends without a result to finish.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_START_STATE:   cfg_start  = value[3:0];
      CFG_ACCEPT_MASK:   cfg_accept = value;
      CFG_STATES_IN_USE: cfg_siu    = value[4:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [3:0] start, input set_t accept, input logic [4:0] siu);
    write_register(CFG_START_STATE, {12'b0, start});
    write_register(CFG_ACCEPT_MASK, accept);
    write_register(CFG_STATES_IN_USE, {11'b0, siu});
  endtask

  // Mostly one destination, sometimes two, so active sets stay interesting.
  function automatic set_t sparse_mask();
    set_t m;
    m = set_t'(1) << $urandom_range(0, NumStates - 1);
    if ($urandom_range(0, 3) == 0) m |= set_t'(1) << $urandom_range(0, NumStates - 1);
    return m;
  endfunction

  task automatic random_load();
    offer_item(op_e'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
               8'($urandom_range(0, 255)), set_t'($urandom_range(0, 65535)),
               1'($urandom_range(0, 1)));
  endtask

  // A small hand-built automaton: an epsilon loop between states 0 and 1,
  // the ampersand as an ordinary symbol, the extreme symbols and masks, an
  // epsilon move taken after the last symbol, a string dropped by an empty
  // item, and a row rewritten in the middle of a string.
  task automatic test_directed_strings();
    offer_item(OP_LOAD_EPS, 4'd0, 8'h00, 16'h0002, 1'b0);
    offer_item(OP_LOAD_EPS, 4'd1, 8'hFF, 16'h0001, 1'b1);
    offer_item(OP_LOAD_SYM, 4'd1, 8'h61, 16'h0004, 1'b0);
    offer_item(OP_LOAD_SYM, 4'd2, AMPERSAND, 16'h8000, 1'b0);
    offer_item(OP_LOAD_SYM, 4'd15, 8'hFF, 16'hFFFF, 1'b0);
    offer_item(OP_LOAD_SYM, 4'd0, 8'h62, 16'h0010, 1'b0);
    offer_item(OP_LOAD_EPS, 4'd4, 8'h00, 16'h8000, 1'b0);
    settle();
    configure(4'd0, 16'h8004, 5'd16);

    feed_empty();
    feed_symbol(8'h61, 1'b1);
    feed_symbol(8'h61, 1'b0);
    feed_symbol(AMPERSAND, 1'b1);
    feed_symbol(8'h61, 1'b0);
    feed_symbol(AMPERSAND, 1'b0);
    feed_symbol(8'hFF, 1'b1);
    feed_symbol(8'h00, 1'b1);
    feed_symbol(8'h62, 1'b1);
    // Abandoned string: the ampersand after the empty item starts afresh.
    feed_symbol(8'h61, 1'b0);
    feed_empty();
    feed_symbol(AMPERSAND, 1'b1);
    // Rewriting a row mid-string affects the next symbol.
    feed_symbol(8'h61, 1'b0);
    offer_item(OP_LOAD_SYM, 4'd2, 8'h61, 16'h8000, 1'b0);
    feed_symbol(8'h61, 1'b1);
    settle();
  endtask

  // Register extremes: a single state, states_in_use of zero and above the
  // state count, a start state out of use, and empty or full accept masks.
  task automatic test_register_extremes();
    configure(4'd0, 16'h0001, 5'd1);
    feed_empty();
    feed_symbol(8'hFF, 1'b1);
    settle();
    configure(4'd15, 16'hFFFF, 5'd0);
    feed_empty();
    feed_symbol(8'h61, 1'b1);
    settle();
    configure(4'd15, 16'hFFFF, 5'd31);
    feed_empty();
    feed_symbol(8'hFF, 1'b1);
    settle();
    configure(4'd2, 16'h0000, 5'd17);
    feed_symbol(AMPERSAND, 1'b1);
    settle();
  endtask

  // Random automata over a four-byte alphabet, fed well-formed strings with
  // some stray bytes, loads in mid-string, empty items and dropped strings.
  task automatic test_random_automata(input int phase, input int n_items);
    logic [7:0] alphabet [4];
    logic [4:0] siu;
    logic [3:0] start;
    int         sent;
    int         kind;
    int         len;
    begin
      calm  = (phase == 1);
      siu   = (phase == 3) ? 5'($urandom_range(1, 4)) : 5'($urandom_range(6, 16));
      start = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, siu - 1));
      configure(start, set_t'($urandom_range(0, 65535) & $urandom_range(0, 65535)), siu);
      for (int k = 0; k < 4; k++) alphabet[k] = 8'($urandom_range(0, 255));
      if (phase == 0) alphabet[0] = AMPERSAND;

      sent = 0;
      for (int s = 0; s < NumStates; s++)
        for (int k = 0; k < 4; k++)
          if ($urandom_range(0, 1) == 1) begin
            offer_item(OP_LOAD_SYM, 4'(s), alphabet[k], sparse_mask(), 1'($urandom_range(0, 1)));
            sent++;
          end
      for (int s = 0; s < NumStates; s++)
        if ($urandom_range(0, 2) == 0) begin
          offer_item(OP_LOAD_EPS, 4'(s), 8'($urandom_range(0, 255)), sparse_mask(), 1'b0);
          sent++;
        end

      while (sent < n_items) begin
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          feed_empty();
          sent++;
        end else if (kind == 1) begin
          random_load();
          sent++;
        end else begin
          len = $urandom_range(1, 6);
          for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 24) == 0) begin
              random_load();
              sent++;
            end
            // Kind 2 leaves the string open and then drops it.
            feed_symbol(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : alphabet[$urandom_range(0, 3)],
                        (j == len - 1) && (kind != 2));
            sent++;
          end
          if (kind == 2) begin
            feed_empty();
            sent++;
          end
        end
      end
      settle();
      calm = 1'b0;
    end
  endtask

  // Result side: after each result, drop ready for a random stall, which may be none.
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    m_axis_tready_i <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
      stall = draw_gap();
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  task automatic log_mismatch(input string what, input int want, input int got);
    err_count++;
    if (err_count <= 10)
      $display("mismatch %0d at cycle %0d: %s expected %0d got %0d",
               err_count, cycle_count, what, want, got);
  endtask

  // Every result taken is matched against the oldest predicted verdict.
  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_verdicts.size() == 0) begin
        log_mismatch("unexpected result, accepted", -1, m_axis_tdata_o[0]);
      end else begin
        want = expected_verdicts.pop_front();
        if (m_axis_tdata_o[0] !== want) log_mismatch("accepted", want, m_axis_tdata_o[0]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("epsilon_nfa_string_acceptor_unit verification failed");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NumStates; s++) begin
      eps_rows[s] = '0;
      for (int b = 0; b < (1 << SymbolWidth); b++) sym_rows[s][b] = '0;
    end
    live_set   = '0;
    mid_string = 1'b0;
    cfg_start  = '0;
    cfg_accept = '0;
    cfg_siu    = 5'd16;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first load waits out the block's clearing sweep on its own.
    test_directed_strings();
    test_register_extremes();
    for (int p = 0; p < 4; p++) test_random_automata(p, 130);

    settle();
    if (err_count == 0 && expected_verdicts.size() == 0)
      $display("epsilon_nfa_string_acceptor_unit verification clean");
    else
      $display("epsilon_nfa_string_acceptor_unit verification failed");
    $finish;
  end

endmodule
